/* rtl/core/sfif_pkg.sv */
// ----------------------------------------------------------------------------
// sfif_pkg
// Shared sizes, types and codes of the spiking fully connected layer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfif_pkg;

   localparam int OUT_NEURONS    = 16;
   localparam int SUB_KERNELS    = 2;
   localparam int CHANNELS       = 8;
   localparam int POSITIONS      = 16;
   localparam int WEIGHT_BITS    = 8;
   localparam int POTENTIAL_BITS = 16;

   localparam int STORE_DEPTH = SUB_KERNELS * CHANNELS * POSITIONS * OUT_NEURONS;
   localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int NEURON_BITS = (OUT_NEURONS > 1) ? $clog2(OUT_NEURONS) : 1;
   localparam int SUB_BITS    = (SUB_KERNELS > 1) ? $clog2(SUB_KERNELS) : 1;

   // fixed field widths of the request, response and threshold, and the threshold reset value
   localparam int CHAN_FIELD_BITS  = 3;
   localparam int POS_FIELD_BITS   = 2;
   localparam int ADDR_FIELD_BITS  = 12;
   localparam int VALUE_FIELD_BITS = 8;
   localparam int FIRED_BITS       = 4;
   localparam int THRESH_BITS      = 15;
   localparam int THRESH_RESET     = 256;

   localparam int CMP_BITS = ((POTENTIAL_BITS > THRESH_BITS) ? POTENTIAL_BITS
                                                             : THRESH_BITS) + 1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_SPIKE = 1'b1;

   typedef logic signed [POTENTIAL_BITS-1:0] potential_type;
   typedef logic signed [WEIGHT_BITS-1:0]    weight_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   typedef struct packed {
      logic          fire;
      potential_type value;
   } update_type;

endpackage

`default_nettype wire

/* rtl/core/sfif_cell.sv */
// ----------------------------------------------------------------------------
// sfif_cell
// One membrane potential of the neuron ring: on a rotate takes shift_in, its neighbor's
// value or, for the tail cell, the updated head value; else on a load (head cell) load_in.
// ----------------------------------------------------------------------------
`default_nettype none

module sfif_cell import sfif_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  potential_type shift_in,
   input  potential_type load_in,
   output potential_type value
);

   potential_type pot_ff;
   potential_type pot_in;

   always_comb begin
      pot_in = pot_ff;
      if (ctrl.shift) begin
         pot_in = shift_in;
      end else if (ctrl.load) begin
         pot_in = load_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pot_ff <= '0;
      end else begin
         pot_ff <= pot_in;
      end
   end

   assign value = pot_ff;

endmodule

`default_nettype wire

/* rtl/core/sfif_update.sv */
// ----------------------------------------------------------------------------
// sfif_update
// Integrate step at the head of the ring: saturating add of one weight and
// the fire decision against the threshold, with the potential cleared on a fire.
// ----------------------------------------------------------------------------
`default_nettype none

module sfif_update import sfif_pkg::*; (
   input  potential_type          head,
   input  weight_type             weight,
   input  logic [THRESH_BITS-1:0] threshold,
   output update_type             result
);

   localparam potential_type POT_MAX = {1'b0, {(POTENTIAL_BITS-1){1'b1}}};
   localparam potential_type POT_MIN = {1'b1, {(POTENTIAL_BITS-1){1'b0}}};

   logic signed [POTENTIAL_BITS:0] sum;
   potential_type                  sat;
   logic signed [CMP_BITS-1:0]     pot_cmp;
   logic signed [CMP_BITS-1:0]     thr_cmp;

   always_comb begin
      sum = (POTENTIAL_BITS+1)'(head) + (POTENTIAL_BITS+1)'(weight);
      // top two bits disagree: the add left the signed range
      if (sum[POTENTIAL_BITS] != sum[POTENTIAL_BITS-1]) begin
         sat = sum[POTENTIAL_BITS] ? POT_MIN : POT_MAX;
      end else begin
         sat = sum[POTENTIAL_BITS-1:0];
      end
      pot_cmp = CMP_BITS'(sat);
      thr_cmp = CMP_BITS'($signed({1'b0, threshold}));
      result.fire  = (pot_cmp >= thr_cmp);
      result.value = result.fire ? '0 : sat;
   end

endmodule

`default_nettype wire

/* rtl/core/spiking_fc_integrate_fire.sv */
// ----------------------------------------------------------------------------
// spiking_fc_integrate_fire
// Event-driven fully connected integrate-and-fire layer built as a ring of
// neuron cells that rotates past one shared integrate step.
// ----------------------------------------------------------------------------
// Requests arrive on req_*: tuser selects a weight load or a spike event.
// A load writes one weight into the single-port weight store. A spike walks
// 16 neurons times 2 sub-kernels, one weight read per cycle while responses
// are not stalled; req_tready stays low until the walk is done, so no new
// request is taken during a walk, and loads are taken one per cycle. The walk
// rate is set by the one read port of the weight store.
// Each fire shows up on rsp_* as the neuron index; tlast marks the last fire
// of a spike. A fire is held until the next fire or the end of the walk so
// that tlast is known. A spike that fires nothing gives no response.
// A spike on a channel outside the layer is dropped.
// Threshold is written through csr_wr_en/csr_wr_data; the user must write it
// only while idle, and the block itself does not enforce this.
// Reset clears the potentials and sets the threshold to 256; the weight
// store is not cleared and must be loaded before spikes read it.
// When rsp_tready is low with a response pending, the walk freezes in place
// and resumes without loss.
// ----------------------------------------------------------------------------
`default_nettype none

module spiking_fc_integrate_fire import sfif_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // spike_channel, spike_row, spike_col, weight_address, weight_value, zeros
   input  logic [31:0]            req_tdata,
   // operation
   input  logic                   req_tuser,
   // response
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // fired_neuron, zeros
   output logic [7:0]             rsp_tdata,
   // last_fire
   output logic                   rsp_tlast,
   // threshold register
   input  logic                   csr_wr_en,
   input  logic [THRESH_BITS-1:0] csr_wr_data
);

   localparam logic [NEURON_BITS-1:0] LAST_NEURON = NEURON_BITS'(OUT_NEURONS - 1);
   localparam logic [SUB_BITS-1:0]    LAST_SUB    = SUB_BITS'(SUB_KERNELS - 1);

   function automatic logic [ADDR_BITS-1:0] weight_index(
      input logic [SUB_BITS-1:0]         s,
      input logic [CHAN_FIELD_BITS-1:0]  ch,
      input logic [2*POS_FIELD_BITS-1:0] pos,
      input logic [NEURON_BITS-1:0]      n
   );
      int idx;
      idx = ((int'(s) * CHANNELS + int'(ch)) * POSITIONS + int'(pos)) * OUT_NEURONS
            + int'(n);
      return ADDR_BITS'(idx);
   endfunction

   // request fields
   logic [CHAN_FIELD_BITS-1:0]  req_channel;
   logic [POS_FIELD_BITS-1:0]   req_row;
   logic [POS_FIELD_BITS-1:0]   req_col;
   logic [ADDR_FIELD_BITS-1:0]  req_address;
   logic signed [VALUE_FIELD_BITS-1:0] req_value;

   assign req_channel = req_tdata[2:0];
   assign req_row     = req_tdata[4:3];
   assign req_col     = req_tdata[6:5];
   assign req_address = req_tdata[18:7];
   assign req_value   = req_tdata[26:19];

   // control
   logic accept;
   logic start;
   logic load_wr;
   logic adv;

   // walk sequencer
   logic                         walk_ff, walk_in;
   logic [NEURON_BITS-1:0]       n_ff, n_in;
   logic [SUB_BITS-1:0]          s_ff, s_in;
   logic [CHAN_FIELD_BITS-1:0]   ch_ff, ch_in;
   logic [2*POS_FIELD_BITS-1:0]  pos_ff, pos_in;
   logic                         a_final;

   // weight store
   weight_type weight_mem [STORE_DEPTH];
   weight_type rd_data_ff;

   // integrate stage
   logic                   b_valid_ff, b_valid_in;
   logic [NEURON_BITS-1:0] b_neuron_ff;
   logic [SUB_BITS-1:0]    b_sub_ff;
   logic                   b_final_ff;
   logic [THRESH_BITS-1:0] thr_ff;
   update_type             upd;
   logic                   fire_b;

   // neuron ring
   potential_type cell_value [OUT_NEURONS];
   potential_type shift_src  [OUT_NEURONS];
   cell_ctrl_type cell_ctrl  [OUT_NEURONS];
   logic          rot_en;
   logic          head_wr;

   // held fire and response register
   logic                   pend_valid_ff, pend_valid_in;
   logic [NEURON_BITS-1:0] pend_neuron_ff, pend_neuron_in;
   logic                   pend_close_ff, pend_close_in;
   logic                   push;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIRED_BITS-1:0]  rsp_neuron_ff;
   logic                   rsp_last_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = !walk_ff;
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && (req_tuser == OP_SPIKE) && (int'(req_channel) < CHANNELS);
   assign load_wr    = accept && (req_tuser == OP_LOAD) && (int'(req_address) < STORE_DEPTH);
   assign a_final    = (n_ff == LAST_NEURON) && (s_ff == LAST_SUB);

   always_comb begin
      walk_in = walk_ff;
      n_in    = n_ff;
      s_in    = s_ff;
      ch_in   = ch_ff;
      pos_in  = pos_ff;
      if (start) begin
         walk_in = 1'b1;
         n_in    = '0;
         s_in    = '0;
         ch_in   = req_channel;
         pos_in  = {req_row, req_col};
      end else if (adv && walk_ff) begin
         if (a_final) begin
            walk_in = 1'b0;
         end
         if (s_ff == LAST_SUB) begin
            s_in = '0;
            n_in = n_ff + 1'b1;
         end else begin
            s_in = s_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= 1'b0;
         n_ff    <= '0;
         s_ff    <= '0;
      end else begin
         walk_ff <= walk_in;
         n_ff    <= n_in;
         s_ff    <= s_in;
      end
      ch_ff  <= ch_in;
      pos_ff <= pos_in;
   end

   // one write on a load, one read per walk step
   always_ff @(posedge clock) begin
      if (load_wr) begin
         weight_mem[ADDR_BITS'(req_address)] <= WEIGHT_BITS'(req_value);
      end
      if (adv && walk_ff) begin
         rd_data_ff <= weight_mem[weight_index(s_ff, ch_ff, pos_ff, n_ff)];
      end
   end

   assign b_valid_in = adv ? walk_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         thr_ff     <= THRESH_BITS'(THRESH_RESET);
      end else begin
         b_valid_ff <= b_valid_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
      if (adv && walk_ff) begin
         b_neuron_ff <= n_ff;
         b_sub_ff    <= s_ff;
         b_final_ff  <= a_final;
      end
   end

   sfif_update u_update (
      .head      (cell_value[0]),
      .weight    (rd_data_ff),
      .threshold (thr_ff),
      .result    (upd)
   );

   assign fire_b  = b_valid_ff && upd.fire;
   assign head_wr = adv && b_valid_ff;
   // ring moves on to the next neuron after its last sub-kernel
   assign rot_en  = head_wr && (b_sub_ff == LAST_SUB);

   for (genvar i = 0; i < OUT_NEURONS; i++) begin : g_ring
      if (i == OUT_NEURONS - 1) begin : g_tail
         assign shift_src[i] = upd.value;
      end else begin : g_mid
         assign shift_src[i] = cell_value[i+1];
      end
      assign cell_ctrl[i].shift = rot_en;
      assign cell_ctrl[i].load  = head_wr && (i == 0);

      sfif_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl[i]),
         .shift_in (shift_src[i]),
         .load_in  (upd.value),
         .value    (cell_value[i])
      );
   end

   // a fire waits here until the next fire or the end of its walk decides tlast
   assign push = pend_valid_ff && (fire_b || pend_close_ff);

   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_neuron_in = pend_neuron_ff;
      pend_close_in  = pend_close_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = push;
         if (fire_b) begin
            pend_valid_in  = 1'b1;
            pend_neuron_in = b_neuron_ff;
            pend_close_in  = b_final_ff;
         end else if (push) begin
            pend_valid_in = 1'b0;
            pend_close_in = 1'b0;
         end else if (b_valid_ff && b_final_ff) begin
            pend_close_in = pend_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_close_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_close_ff <= pend_close_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_neuron_ff <= pend_neuron_in;
      if (adv && push) begin
         rsp_neuron_ff <= FIRED_BITS'(pend_neuron_ff);
         rsp_last_ff   <= pend_close_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8-FIRED_BITS){1'b0}}, rsp_neuron_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_close_has_fire : assert property (@(posedge clock) disable iff (reset)
      pend_close_ff |-> pend_valid_ff)
      else $error("closing mark without a held fire");

   a_final_step : assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_final_ff) |-> (b_neuron_ff == LAST_NEURON && b_sub_ff == LAST_SUB))
      else $error("walk ended away from the last neuron and sub-kernel");

   a_walk_start : assert property (@(posedge clock) disable iff (reset)
      $rose(walk_ff) |-> (n_ff == '0 && s_ff == '0))
      else $error("walk started with nonzero step counters");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !adv) |=> (b_valid_ff && $stable(b_neuron_ff) && $stable(b_sub_ff)))
      else $error("integrate stage moved during a response stall");

endmodule

`default_nettype wire
